@@ rtl/tdef_pkg.sv @@
// ----------------------------------------------------------------------------
// tdef_pkg
// Shared types and codes of the table-driven entity state machine engine.
// ----------------------------------------------------------------------------
package tdef_pkg;

  // function codes
  localparam logic [2:0] FN_LOAD_TRANS = 3'd0;
  localparam logic [2:0] FN_LOAD_ANIM  = 3'd1;
  localparam logic [2:0] FN_ATTACH     = 3'd2;
  localparam logic [2:0] FN_DETACH     = 3'd3;
  localparam logic [2:0] FN_TRIGGER    = 3'd4;
  localparam logic [2:0] FN_QUERY      = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ALREADY = 2'd1;
  localparam logic [1:0] ST_NOT_ATT = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  controller_id;
    logic [5:0]  entity_slot;
    logic [3:0]  entry_index;
    logic [15:0] from_state;
    logic [15:0] event_code;
    logic [15:0] to_state;
    logic [15:0] anim_handle;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        transitioned;
    logic [15:0] current_state;
    logic        is_attached;
    logic        anim_found;
    logic [3:0]  anim_index;
    logic [15:0] anim_out;
  } out_word_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_ENT   = 5'b00100,
    S_TSCAN = 5'b01000,
    S_ASCAN = 5'b10000
  } seq_state_t;

endpackage

@@ rtl/tdef_ram.sv @@
// ----------------------------------------------------------------------------
// tdef_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tdef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[raddr];
  end

endmodule

@@ rtl/table_driven_entity_fsm.sv @@
// ----------------------------------------------------------------------------
// table_driven_entity_fsm
// Programmable per-entity state machine engine built around three RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_word and raise start; the word is taken on a
//   rising edge with start high and busy low. One result word per command
//   appears on out_word for exactly one cycle with out_valid high; the
//   receiver cannot stall it.
//   Loads, detach and unused codes: result in the cycle after acceptance,
//   busy stays low, so one such command can be taken every cycle.
//   Query: entity read, then an animation scan over at most
//   ENTRIES_PER_CONTROLLER entries (one RAM read per cycle; stops at the
//   first hit); result on the cycle after the scan ends.
//   Attach/trigger: entity read, transition scan, animation scan; busy
//   drops as the result word appears. The scans are bound by the single
//   read port of each table RAM.
//   Reset: after rst_n, a clearing pass of max(NUM_CONTROLLERS *
//   ENTRIES_PER_CONTROLLER, NUM_ENTITIES) cycles (128 by default) zeroes all
//   tables; busy is high during it.
// ----------------------------------------------------------------------------
module table_driven_entity_fsm
  import tdef_pkg::*;
#(
  parameter int NUM_CONTROLLERS        = 8,
  parameter int ENTRIES_PER_CONTROLLER = 16,
  parameter int NUM_ENTITIES           = 64,
  parameter int SYMBOL_BITS            = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int EPC     = ENTRIES_PER_CONTROLLER;
  localparam int SW      = SYMBOL_BITS;
  localparam int CTRL_W  = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;
  localparam int IDX_W   = (EPC > 1) ? $clog2(EPC) : 1;
  localparam int TDEPTH  = NUM_CONTROLLERS * EPC;
  localparam int TADDR_W = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int EADDR_W = (NUM_ENTITIES > 1) ? $clog2(NUM_ENTITIES) : 1;
  localparam int CNT_W   = $clog2(EPC + 1);
  localparam int TR_W    = 1 + 3 * SW;
  localparam int AN_W    = 1 + SW + 16;
  localparam int EN_W    = 1 + CTRL_W + SW;
  localparam int CLR_N   = (TDEPTH > NUM_ENTITIES) ? TDEPTH : NUM_ENTITIES;
  localparam int CLR_W   = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(EPC);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);

  // sequencer registers
  seq_state_t         state_r, state_nxt;
  logic [CLR_W-1:0]   clr_r, clr_nxt;
  in_word_t           op_r, op_nxt;
  logic [CTRL_W-1:0]  ctrl_r, ctrl_nxt;
  logic [TADDR_W-1:0] base_r, base_nxt;
  logic [SW-1:0]      st_r, st_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               dv_r, dv_nxt;
  logic [IDX_W-1:0]   didx_r, didx_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic               xfer_r, xfer_nxt;
  logic               out_valid_r;
  out_word_t          out_word_r, out_nxt;
  logic               emit;

  // RAM ports
  logic               t_we, a_we, e_we;
  logic [TADDR_W-1:0] t_waddr, a_waddr, scan_addr;
  logic [EADDR_W-1:0] e_waddr, e_raddr;
  logic [TR_W-1:0]    t_wdata, t_rdata;
  logic [AN_W-1:0]    a_wdata, a_rdata;
  logic [EN_W-1:0]    e_wdata, e_rdata;

  // decoded read data
  logic               t_valid, a_valid, e_att;
  logic [SW-1:0]      t_from, t_ev, t_to, a_st, e_st, new_st;
  logic [15:0]        a_handle;
  logic [CTRL_W-1:0]  e_ctrl, ctrl_sel;
  logic [TADDR_W-1:0] base_calc, ld_addr;
  logic               t_hit, a_hit, is_attach;
  logic               slot_ok, entry_ok, op_ctrl_ok;

  assign t_valid  = t_rdata[TR_W-1];
  assign t_from   = t_rdata[3*SW-1:2*SW];
  assign t_ev     = t_rdata[2*SW-1:SW];
  assign t_to     = t_rdata[SW-1:0];
  assign a_valid  = a_rdata[AN_W-1];
  assign a_st     = a_rdata[SW+15:16];
  assign a_handle = a_rdata[15:0];
  assign e_att    = e_rdata[EN_W-1];
  assign e_ctrl   = e_rdata[SW+CTRL_W-1:SW];
  assign e_st     = e_rdata[SW-1:0];

  assign slot_ok    = 32'(in_word.entity_slot) < NUM_ENTITIES;
  assign entry_ok   = (32'(in_word.controller_id) < NUM_CONTROLLERS) &&
                      (32'(in_word.entry_index) < EPC);
  assign op_ctrl_ok = 32'(op_r.controller_id) < NUM_CONTROLLERS;
  assign is_attach  = (op_r.func == FN_ATTACH);

  assign ld_addr   = TADDR_W'(32'(in_word.controller_id) * EPC +
                              32'(in_word.entry_index));
  assign ctrl_sel  = (is_attach && !e_att) ? CTRL_W'(op_r.controller_id) : e_ctrl;
  assign base_calc = TADDR_W'(32'(ctrl_sel) * EPC);
  assign scan_addr = TADDR_W'(32'(base_r) + 32'(cnt_r));
  assign e_raddr   = EADDR_W'(in_word.entity_slot);

  // attach takes the first valid entry; trigger needs state and event match
  assign t_hit  = t_valid &&
                  (is_attach || (t_from == st_r && t_ev == SW'(op_r.event_code)));
  assign a_hit  = a_valid && (a_st == st_r);
  assign new_st = is_attach ? t_from : t_to;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    ctrl_nxt  = ctrl_r;
    base_nxt  = base_r;
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    dv_nxt    = 1'b0;
    didx_nxt  = didx_r;
    stat_nxt  = stat_r;
    xfer_nxt  = xfer_r;
    emit      = 1'b0;
    out_nxt   = '0;
    t_we      = 1'b0;
    t_waddr   = ld_addr;
    t_wdata   = {1'b1, SW'(in_word.from_state), SW'(in_word.event_code),
                 SW'(in_word.to_state)};
    a_we      = 1'b0;
    a_waddr   = ld_addr;
    a_wdata   = {1'b1, SW'(in_word.from_state), in_word.anim_handle};
    e_we      = 1'b0;
    e_waddr   = EADDR_W'(op_r.entity_slot);
    e_wdata   = {1'b1, ctrl_r, new_st};

    unique case (state_r)
      S_CLEAR: begin
        t_we    = 32'(clr_r) < TDEPTH;
        t_waddr = TADDR_W'(clr_r);
        t_wdata = '0;
        a_we    = 32'(clr_r) < TDEPTH;
        a_waddr = TADDR_W'(clr_r);
        a_wdata = '0;
        e_we    = 32'(clr_r) < NUM_ENTITIES;
        e_waddr = EADDR_W'(clr_r);
        e_wdata = '0;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_nxt   = in_word;
          stat_nxt = ST_OK;
          xfer_nxt = 1'b0;
          unique case (in_word.func)
            FN_LOAD_TRANS: begin
              t_we = entry_ok;
              emit = 1'b1;
            end
            FN_LOAD_ANIM: begin
              a_we = entry_ok;
              emit = 1'b1;
            end
            FN_DETACH: begin
              e_we    = slot_ok;
              e_waddr = EADDR_W'(in_word.entity_slot);
              e_wdata = '0;
              emit    = 1'b1;
            end
            FN_ATTACH, FN_TRIGGER, FN_QUERY: begin
              if (!slot_ok) begin
                emit           = 1'b1;
                out_nxt.status = ST_NOT_ATT;
              end else begin
                state_nxt = S_ENT;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end

      S_ENT: begin
        cnt_nxt  = '0;
        base_nxt = base_calc;
        ctrl_nxt = ctrl_sel;
        st_nxt   = e_st;
        if (is_attach) begin
          if (e_att) begin
            stat_nxt  = ST_ALREADY;
            state_nxt = S_ASCAN;
          end else if (!op_ctrl_ok) begin
            emit           = 1'b1;
            out_nxt.status = ST_EMPTY;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_TSCAN;
          end
        end else if (!e_att) begin
          emit           = 1'b1;
          out_nxt.status = ST_NOT_ATT;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = (op_r.func == FN_TRIGGER) ? S_TSCAN : S_ASCAN;
        end
      end

      S_TSCAN: begin
        if (cnt_r != CNT_END) begin
          cnt_nxt  = cnt_r + 1'b1;
          dv_nxt   = 1'b1;
          didx_nxt = IDX_W'(cnt_r);
        end
        if (dv_r && t_hit) begin
          st_nxt    = new_st;
          xfer_nxt  = !is_attach;
          e_we      = 1'b1;
          cnt_nxt   = '0;
          dv_nxt    = 1'b0;
          state_nxt = S_ASCAN;
        end else if (!dv_r && cnt_r == CNT_END) begin
          if (is_attach) begin
            emit           = 1'b1;
            out_nxt.status = ST_EMPTY;
            state_nxt      = S_IDLE;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_ASCAN;
          end
        end
      end

      S_ASCAN: begin
        if (cnt_r != CNT_END) begin
          cnt_nxt  = cnt_r + 1'b1;
          dv_nxt   = 1'b1;
          didx_nxt = IDX_W'(cnt_r);
        end
        out_nxt.status        = stat_r;
        out_nxt.transitioned  = xfer_r;
        out_nxt.current_state = 16'(st_r);
        out_nxt.is_attached   = 1'b1;
        if (dv_r && a_hit) begin
          emit               = 1'b1;
          out_nxt.anim_found = 1'b1;
          out_nxt.anim_index = 4'(didx_r);
          out_nxt.anim_out   = a_handle;
          state_nxt          = S_IDLE;
        end else if (!dv_r && cnt_r == CNT_END) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    ctrl_r <= ctrl_nxt;
    base_r <= base_nxt;
    st_r   <= st_nxt;
    didx_r <= didx_nxt;
    stat_r <= stat_nxt;
    xfer_r <= xfer_nxt;
    if (emit) begin
      out_word_r <= out_nxt;
    end
  end

  tdef_ram #(.WIDTH(TR_W), .DEPTH(TDEPTH)) u_trans_ram (
    .clk       (clk),
    .we        (t_we),
    .waddr     (t_waddr),
    .wdata     (t_wdata),
    .raddr     (scan_addr),
    .rd_data_r (t_rdata)
  );

  tdef_ram #(.WIDTH(AN_W), .DEPTH(TDEPTH)) u_anim_ram (
    .clk       (clk),
    .we        (a_we),
    .waddr     (a_waddr),
    .wdata     (a_wdata),
    .raddr     (scan_addr),
    .rd_data_r (a_rdata)
  );

  tdef_ram #(.WIDTH(EN_W), .DEPTH(NUM_ENTITIES)) u_ent_ram (
    .clk       (clk),
    .we        (e_we),
    .waddr     (e_waddr),
    .wdata     (e_wdata),
    .raddr     (e_raddr),
    .rd_data_r (e_rdata)
  );

endmodule

@@ rtl/tdef_chk.sv @@
// ----------------------------------------------------------------------------
// tdef_chk
// Port-level checks of the entity state machine engine, bound to the top.
// ----------------------------------------------------------------------------
module tdef_chk
  import tdef_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word,
  input logic      out_valid,
  input out_word_t out_word
);

  // loads, detach and unused codes answer in the very next cycle
  a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.func != FN_ATTACH && in_word.func != FN_TRIGGER &&
     in_word.func != FN_QUERY)
    |=> out_valid)
    else $error("short command gave no word in the next cycle");

  // a word only follows an accepted command or a busy cycle
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result word without a command");

  // a detached view carries no state and no animation
  a_detached_view: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.is_attached) |->
    (out_word.current_state == 16'd0 && !out_word.anim_found &&
     !out_word.transitioned && out_word.anim_out == 16'd0))
    else $error("detached entity reported with content");

  // a transition always leaves the entity attached with status ok
  a_xfer_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.transitioned) |->
    (out_word.status == ST_OK && out_word.is_attached))
    else $error("transition reported with bad status");

endmodule

bind table_driven_entity_fsm tdef_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);

@@ tb/sv/table_driven_entity_fsm_test.sv @@
// ----------------------------------------------------------------------------
// table_driven_entity_fsm_test
// Drives command words into the state machine engine and checks every result
// word against a shadow copy of the transition, animation and entity tables.
// A directed pass covers the corner cases; weighted random traffic on a small
// symbol alphabet then keeps transitions firing.
// ----------------------------------------------------------------------------
module table_driven_entity_fsm_test;
  import tdef_pkg::*;

  // codes the package leaves unnamed; the block must answer them with zeros
  localparam logic [2:0] FN_SPARE_A = 3'd6;
  localparam logic [2:0] FN_SPARE_B = 3'd7;

  localparam int RANDOM_CMDS = 1000;
  localparam int DRAIN_CYCLES = 50;

  // Shadow of the engine tables; predicts one result word per command.
  class fsm_shadow;
    localparam int CTRLS    = 8;
    localparam int SLOTS    = 16;
    localparam int ENTITIES = 64;

    typedef struct packed {
      logic        valid;
      logic [15:0] src;
      logic [15:0] ev;
      logic [15:0] dst;
    } trans_rec_t;

    typedef struct packed {
      logic        valid;
      logic [15:0] st;
      logic [15:0] handle;
    } anim_rec_t;

    typedef struct packed {
      logic        attached;
      logic [2:0]  ctrl;
      logic [15:0] st;
    } ent_rec_t;

    trans_rec_t trans_mem [CTRLS*SLOTS];
    anim_rec_t  anim_mem [CTRLS*SLOTS];
    ent_rec_t   ent_mem [ENTITIES];
    out_word_t  expected_words [$];
    int         errors;

    function new();
      foreach (trans_mem[i]) trans_mem[i] = '0;
      foreach (anim_mem[i]) anim_mem[i] = '0;
      foreach (ent_mem[i]) ent_mem[i] = '0;
      errors = 0;
    endfunction

    // state, attach flag and first matching animation entry of one entity
    function out_word_t entity_view(logic [5:0] slot, out_word_t r);
      anim_rec_t a;
      logic      hit;
      hit = 1'b0;
      if (!ent_mem[slot].attached) return r;
      r.current_state = ent_mem[slot].st;
      r.is_attached   = 1'b1;
      for (int i = 0; i < SLOTS && !hit; i++) begin
        a = anim_mem[ent_mem[slot].ctrl * SLOTS + i];
        if (a.valid && a.st == ent_mem[slot].st) begin
          hit          = 1'b1;
          r.anim_found = 1'b1;
          r.anim_index = 4'(i);
          r.anim_out   = a.handle;
        end
      end
      return r;
    endfunction

    function void note_command(in_word_t w);
      out_word_t  r;
      trans_rec_t t;
      logic       hit;
      int         base;
      r    = '0;
      hit  = 1'b0;
      base = w.controller_id * SLOTS;
      case (w.func)
        FN_LOAD_TRANS: begin
          trans_mem[base + w.entry_index] = '{1'b1, w.from_state, w.event_code, w.to_state};
        end
        FN_LOAD_ANIM: begin
          anim_mem[base + w.entry_index] = '{1'b1, w.from_state, w.anim_handle};
        end
        FN_ATTACH: begin
          if (ent_mem[w.entity_slot].attached) begin
            r.status = ST_ALREADY;
            r = entity_view(w.entity_slot, r);
          end else begin
            r.status = ST_EMPTY;
            // entity starts in the source state of the first valid transition
            for (int i = 0; i < SLOTS && !hit; i++) begin
              t = trans_mem[base + i];
              if (t.valid) begin
                hit = 1'b1;
                ent_mem[w.entity_slot] = '{1'b1, w.controller_id, t.src};
                r.status = ST_OK;
                r = entity_view(w.entity_slot, r);
              end
            end
          end
        end
        FN_DETACH: ent_mem[w.entity_slot].attached = 1'b0;
        FN_TRIGGER: begin
          if (!ent_mem[w.entity_slot].attached) begin
            r.status = ST_NOT_ATT;
          end else begin
            base = ent_mem[w.entity_slot].ctrl * SLOTS;
            for (int i = 0; i < SLOTS && !hit; i++) begin
              t = trans_mem[base + i];
              if (t.valid && t.src == ent_mem[w.entity_slot].st && t.ev == w.event_code) begin
                hit = 1'b1;
                ent_mem[w.entity_slot].st = t.dst;
                r.transitioned = 1'b1;
              end
            end
            r = entity_view(w.entity_slot, r);
          end
        end
        FN_QUERY: begin
          if (!ent_mem[w.entity_slot].attached) r.status = ST_NOT_ATT;
          else r = entity_view(w.entity_slot, r);
        end
        default: ;
      endcase
      expected_words.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: result word %h with none expected", $time, got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("transitioned", want.transitioned, got.transitioned);
      compare_field("current_state", want.current_state, got.current_state);
      compare_field("is_attached", want.is_attached, got.is_attached);
      compare_field("anim_found", want.anim_found, got.anim_found);
      compare_field("anim_index", want.anim_index, got.anim_index);
      compare_field("anim_out", want.anim_out, got.anim_out);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;

  fsm_shadow shadow;
  int        calm_left = 0;

  table_driven_entity_fsm u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) shadow.check_word(out_word);
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  function automatic in_word_t cmd(logic [2:0] fn, logic [2:0] ctrl, logic [5:0] slot,
                                   logic [3:0] idx, logic [15:0] src, logic [15:0] ev,
                                   logic [15:0] dst, logic [15:0] handle);
    return '{fn, ctrl, slot, idx, src, ev, dst, handle};
  endfunction

  // mostly a tiny alphabet so lookups hit, sometimes any 16-bit value
  function automatic logic [15:0] pick_sym();
    if ($urandom_range(0, 6) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 3));
  endfunction

  function automatic in_word_t random_cmd();
    in_word_t w;
    int       roll;
    roll            = $urandom_range(0, 99);
    w.controller_id = 3'($urandom_range(0, 7));
    w.entity_slot   = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, 7));
    w.entry_index   = 4'($urandom_range(0, 15));
    w.from_state    = pick_sym();
    w.event_code    = pick_sym();
    w.to_state      = pick_sym();
    w.anim_handle   = 16'($urandom);
    if (roll < 15)      w.func = FN_LOAD_TRANS;
    else if (roll < 27) w.func = FN_LOAD_ANIM;
    else if (roll < 39) w.func = FN_ATTACH;
    else if (roll < 45) w.func = FN_DETACH;
    else if (roll < 80) w.func = FN_TRIGGER;
    else if (roll < 95) w.func = FN_QUERY;
    else w.func = roll[0] ? FN_SPARE_A : FN_SPARE_B;
    return w;
  endfunction

  // start stays high across back-to-back words; it only drops for a gap
  task automatic send_cmd(input in_word_t w);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    shadow.note_command(w);
  endtask

  initial begin
    int       taken;
    in_word_t w;
    shadow = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: detached entities, empty controller, spare codes
    send_cmd(cmd(FN_QUERY, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd(FN_TRIGGER, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd(FN_ATTACH, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd(FN_DETACH, 0, 63, 0, 0, 0, 0, 0));
    send_cmd(cmd(FN_SPARE_A, 7, 63, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_cmd(cmd(FN_SPARE_B, 7, 63, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // controller 7: gaps in both lists, duplicate animation state at 0 and 5
    send_cmd(cmd(FN_LOAD_TRANS, 7, 0, 15, 16'hFFFF, 16'hFFFF, 16'h0000, 0));
    send_cmd(cmd(FN_LOAD_TRANS, 7, 0, 3, 16'h0000, 16'h0001, 16'hFFFF, 0));
    send_cmd(cmd(FN_LOAD_ANIM, 7, 0, 15, 16'hFFFF, 0, 0, 16'hFFFF));
    send_cmd(cmd(FN_LOAD_ANIM, 7, 0, 0, 16'h0000, 0, 0, 16'h1234));
    send_cmd(cmd(FN_LOAD_ANIM, 7, 0, 5, 16'h0000, 0, 0, 16'hBEEF));
    send_cmd(cmd(FN_ATTACH, 7, 63, 0, 0, 0, 0, 0));
    send_cmd(cmd(FN_ATTACH, 7, 63, 0, 0, 0, 0, 0));
    send_cmd(cmd(FN_TRIGGER, 0, 63, 0, 0, 16'h0002, 0, 0));
    send_cmd(cmd(FN_TRIGGER, 0, 63, 0, 0, 16'h0001, 0, 0));
    send_cmd(cmd(FN_TRIGGER, 0, 63, 0, 0, 16'hFFFF, 0, 0));
    send_cmd(cmd(FN_QUERY, 0, 63, 0, 0, 0, 0, 0));
    // reload under an attached entity
    send_cmd(cmd(FN_LOAD_TRANS, 7, 0, 3, 16'h0000, 16'h0000, 16'h00AA, 0));
    send_cmd(cmd(FN_TRIGGER, 0, 63, 0, 0, 16'h0000, 0, 0));
    send_cmd(cmd(FN_DETACH, 0, 63, 0, 0, 0, 0, 0));
    send_cmd(cmd(FN_QUERY, 0, 63, 0, 0, 0, 0, 0));
    send_cmd(cmd(FN_DETACH, 0, 63, 0, 0, 0, 0, 0));
    send_cmd(cmd(FN_ATTACH, 7, 0, 0, 0, 0, 0, 0));

    taken = 0;
    while (taken < RANDOM_CMDS) begin
      w = random_cmd();
      send_cmd(w);
      if (w.func <= FN_QUERY) taken++;
    end
    start <= 1'b0;

    while (shadow.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tdef_pkg.sv
rtl/tdef_ram.sv
rtl/table_driven_entity_fsm.sv
rtl/tdef_chk.sv
tb/sv/table_driven_entity_fsm_test.sv
